// ===== rtl/core/tfba_pkg.sv =====
// shared types, constants and helpers for the tx fifo bump allocator
package tfba_pkg;

    localparam int DEF_ENDPOINTS = 6;

    localparam int START_W = 16;
    localparam int SIZE_W  = 10;
    localparam int EPN_W   = 5;
    localparam int ALU_W   = 17;

    localparam logic [START_W-1:0] FREE_LIMIT = 16'h0200;
    localparam logic [SIZE_W-1:0]  FREE_SIZE  = 10'h200;
    localparam logic [SIZE_W-1:0]  MIN_WORDS  = 10'd16;
    localparam logic [ALU_W-1:0]   ROUND_ADD  = 17'd3;

    localparam logic [15:0] RST_EP0_START = 16'd56;
    localparam logic [15:0] RST_EP0_DEPTH = 16'd16;
    localparam logic [15:0] RST_TOTAL     = 16'd320;

    typedef enum logic [1:0] {
        FUNC_ALLOC       = 2'd0,
        FUNC_RELEASE     = 2'd1,
        FUNC_RELEASE_ALL = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        CFG_EP0_START = 2'd0,
        CFG_EP0_DEPTH = 2'd1,
        CFG_TOTAL     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] endpoint;
        logic [9:0] request_bytes;
        logic       double_size;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [15:0] start_word;
        logic [10:0] size_words;
    } t_out_item;

    // slot table write command
    typedef struct packed {
        logic               wr_one;
        logic               wr_all;
        logic               free;
        logic [2:0]         ep;
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
    } t_slot_cmd;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic [ALU_W-1:0] c;
        logic             wrap;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             gt;
    } t_alu_rsp;

    // start word of the free marker for an endpoint
    function automatic logic [START_W-1:0] free_start(input logic [EPN_W-1:0] ep);
        logic [START_W-1:0] base;
        base = {2'b00, ep, 9'd0};
        return base + 16'h0200;
    endfunction

endpackage

// ===== rtl/core/tx_fifo_bump_allocator.sv =====
// top level: sequencer, configuration registers and result register
// Transmit FIFO region allocator for a shared word-addressed FIFO memory.
// Command channel: i_valid / o_stall with payload i_in (func, endpoint,
// request_bytes, double_size); a transfer happens when i_valid is high and
// o_stall is low. Result channel: o_valid / i_stall with payload o_out
// (ok, start_word, size_words); exactly one result per command.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 ep0 start, 1 ep0 depth, 2 total words; other indexes are ignored.
// Write configuration only while no command is in flight.
// Timing: release, release-all and rejected commands present their result
// in the cycle after the transfer. An allocate presents it after a step for
// the ep0 region end, one per slot scanned through the shared adder/compare
// unit, one for the word rounding and one for the fit check. One command is
// handled at a time; o_stall stays high until the result has been taken.
// Reset (synchronous, active low) frees every slot and loads the default
// configuration. While i_stall holds, the result register keeps its value
// and no new command is taken.
module tx_fifo_bump_allocator #(
    parameter int ENDPOINTS = tfba_pkg::DEF_ENDPOINTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tfba_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output tfba_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import tfba_pkg::*;

    localparam int SLOTS = ENDPOINTS - 1;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EP0   = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_WORDS = 6'b001000,
        ST_FIT   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_item, n_item;
    logic [START_W-1:0] r_fsa, n_fsa;
    logic [SIZE_W-1:0]  r_words, n_words;
    logic [IDX_W-1:0]   r_idx, n_idx;
    t_out_item          r_out, n_out;
    logic [15:0]        r_ep0_start, r_ep0_depth, r_total;

    t_slot_cmd          w_cmd;
    t_alu_req           w_req;
    t_alu_rsp           w_rsp;
    logic [START_W-1:0] w_rd_start;
    logic [SIZE_W-1:0]  w_rd_size;
    logic               w_ep_ok;
    logic [10:0]        w_bytes;
    logic [SIZE_W-1:0]  w_words;

    tfba_slots #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_rd_idx   (r_idx),
        .o_rd_start (w_rd_start),
        .o_rd_size  (w_rd_size)
    );

    tfba_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = (r_state == ST_OUT);
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ep0_start <= RST_EP0_START;
            r_ep0_depth <= RST_EP0_DEPTH;
            r_total     <= RST_TOTAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_EP0_START: r_ep0_start <= i_cfg_data;
                CFG_EP0_DEPTH: r_ep0_depth <= i_cfg_data;
                CFG_TOTAL:     r_total     <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    assign w_ep_ok = ({29'd0, i_in.endpoint} < 32'(ENDPOINTS));
    assign w_bytes = r_item.double_size ? {r_item.request_bytes, 1'b0}
                                        : {1'b0, r_item.request_bytes};
    assign w_words = w_rsp.sum[11:2];

    // operand select for the shared unit
    always_comb begin
        w_req = '0;
        case (r_state)
            ST_EP0: begin
                w_req.a    = {1'b0, r_ep0_start};
                w_req.b    = {1'b0, r_ep0_depth};
                w_req.wrap = 1'b1;
            end
            ST_SCAN: begin
                w_req.a    = {1'b0, w_rd_start};
                w_req.b    = ALU_W'(w_rd_size);
                w_req.c    = {1'b0, r_fsa};
                w_req.wrap = 1'b1;
            end
            ST_WORDS: begin
                w_req.a = ALU_W'(w_bytes);
                w_req.b = ROUND_ADD;
            end
            ST_FIT: begin
                w_req.a = {1'b0, r_fsa};
                w_req.b = ALU_W'(r_words);
                w_req.c = {1'b0, r_total};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_fsa   = r_fsa;
        n_words = r_words;
        n_idx   = r_idx;
        n_out   = r_out;
        w_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_item  = i_in;
                    n_out   = '0;
                    n_state = ST_OUT;
                    case (i_in.func)
                        FUNC_ALLOC: begin
                            if (w_ep_ok && i_in.endpoint != 3'd0) begin
                                n_state = ST_EP0;
                            end
                        end
                        FUNC_RELEASE: begin
                            if (w_ep_ok) begin
                                n_out.ok     = 1'b1;
                                w_cmd.wr_one = (i_in.endpoint != 3'd0);
                                w_cmd.free   = 1'b1;
                                w_cmd.ep     = i_in.endpoint;
                            end
                        end
                        FUNC_RELEASE_ALL: begin
                            n_out.ok     = 1'b1;
                            w_cmd.wr_all = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EP0: begin
                n_fsa   = w_rsp.sum[START_W-1:0];
                n_idx   = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // only slots whose start is below the free limit take part in the highest-end search
                if (w_rd_start < FREE_LIMIT && w_rsp.gt) begin
                    n_fsa = w_rsp.sum[START_W-1:0];
                end
                if (r_idx == LAST_IDX) begin
                    n_state = ST_WORDS;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_WORDS: begin
                n_words = (w_words < MIN_WORDS) ? MIN_WORDS : w_words;
                n_state = ST_FIT;
            end
            ST_FIT: begin
                if (!w_rsp.gt) begin
                    w_cmd.wr_one     = 1'b1;
                    w_cmd.ep         = r_item.endpoint;
                    w_cmd.start      = r_fsa;
                    w_cmd.size       = r_words;
                    n_out.ok         = 1'b1;
                    n_out.start_word = r_fsa;
                    n_out.size_words = {1'b0, r_words};
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_fsa   <= n_fsa;
        r_words <= n_words;
        r_idx   <= n_idx;
        r_out   <= n_out;
    end

    // a successful allocate respects the minimum size
    a_min_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.ok && o_out.size_words != 11'd0
            |-> o_out.size_words >= {1'b0, MIN_WORDS})
        else $error("allocated region below minimum size");

    // a successful allocate fits inside the fifo memory
    a_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.ok && o_out.size_words != 11'd0
            |-> ({1'b0, o_out.start_word} + 17'(o_out.size_words)) <= {1'b0, r_total})
        else $error("allocated region passes the total");

    // a failed command reports no region
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.ok |-> o_out.start_word == 16'd0 && o_out.size_words == 11'd0)
        else $error("failed command reports a region");

    // a stalled result holds its value
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("stalled result changed");

endmodule

// ===== rtl/core/tfba_alu.sv =====
// shared adder and magnitude compare used by the ep0, scan, rounding and fit steps
module tfba_alu (
    input  tfba_pkg::t_alu_req i_req,
    output tfba_pkg::t_alu_rsp o_rsp
);
    import tfba_pkg::*;

    logic [ALU_W-1:0] w_sum;
    logic [ALU_W-1:0] w_res;

    assign w_sum = i_req.a + i_req.b;
    // region ends wrap at 16 bits
    assign w_res = i_req.wrap ? {1'b0, w_sum[ALU_W-2:0]} : w_sum;

    assign o_rsp.sum = w_res;
    assign o_rsp.gt  = w_res > i_req.c;

endmodule

// ===== rtl/core/tfba_slots.sv =====
// slot table for the endpoints other than ep0: start and size of each transmit region
module tfba_slots #(
    parameter int SLOTS = tfba_pkg::DEF_ENDPOINTS - 1,
    parameter int IDX_W = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tfba_pkg::t_slot_cmd          i_cmd,
    input  logic [IDX_W-1:0]             i_rd_idx,
    output logic [tfba_pkg::START_W-1:0] o_rd_start,
    output logic [tfba_pkg::SIZE_W-1:0]  o_rd_size
);
    import tfba_pkg::*;

    logic [START_W-1:0] r_start [SLOTS];
    logic [SIZE_W-1:0]  r_size  [SLOTS];

    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        localparam logic [EPN_W-1:0] EP_NUM = EPN_W'(g + 1);
        logic w_hit;

        assign w_hit = i_cmd.wr_one && (EP_NUM == {2'b00, i_cmd.ep});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_cmd.wr_all || (w_hit && i_cmd.free)) begin
                r_start[g] <= free_start(EP_NUM);
                r_size[g]  <= FREE_SIZE;
            end else if (w_hit) begin
                r_start[g] <= i_cmd.start;
                r_size[g]  <= i_cmd.size;
            end
        end
    end

    assign o_rd_start = r_start[i_rd_idx];
    assign o_rd_size  = r_size[i_rd_idx];

endmodule

// ===== tb/tb_tx_fifo_bump_allocator.sv =====
// self-checking testbench for the tx fifo bump allocator with a built-in slot table predictor
module tb_tx_fifo_bump_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import tfba_pkg::*;

    localparam int ENDPOINTS = DEF_ENDPOINTS;
    localparam int LIMIT = 200000;
    localparam int SETTLE_CYCLES = ENDPOINTS + 8;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in_item i_in = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out_item o_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // predictor state: configuration and slot table
    logic [15:0] ep0_start = RST_EP0_START;
    logic [15:0] ep0_depth = RST_EP0_DEPTH;
    logic [15:0] fifo_total = RST_TOTAL;
    logic [15:0] slot_start [1:ENDPOINTS-1];
    logic [15:0] slot_size [1:ENDPOINTS-1];

    t_in_item cmd_queue [$];
    t_out_item region_answers [$];
    t_out_item want;
    int unsigned gap_pct = 11;
    int fail_count = 0;
    int cycle_count = 0;

    tx_fifo_bump_allocator #(.ENDPOINTS(ENDPOINTS)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_in(i_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out(o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void free_slot(input int ep);
        slot_start[ep] = 16'((ep + 1) << 9);
        slot_size[ep] = 16'h0200;
    endfunction

    function automatic t_out_item apply_fifo_cmd(input t_in_item c);
        t_out_item r;
        logic [15:0] top;
        logic [15:0] tail;
        logic [11:0] bytes;
        logic [10:0] words;
        int i;
        r = '0;
        case (c.func)
            FUNC_ALLOC: begin
                if (c.endpoint != 0 && c.endpoint < ENDPOINTS) begin
                    top = ep0_start + ep0_depth;
                    // slots whose start is at or above the free limit are skipped
                    for (i = 1; i < ENDPOINTS; i++) begin
                        if (slot_start[i] < FREE_LIMIT) begin
                            tail = slot_start[i] + slot_size[i];
                            if (tail > top) top = tail;
                        end
                    end
                    bytes = c.double_size ? {1'b0, c.request_bytes, 1'b0}
                                          : {2'b00, c.request_bytes};
                    words = 11'((bytes + 12'd3) >> 2);
                    if (words < 11'(MIN_WORDS)) words = 11'(MIN_WORDS);
                    if ({1'b0, top} + 17'(words) <= {1'b0, fifo_total}) begin
                        slot_start[c.endpoint] = top;
                        slot_size[c.endpoint] = 16'(words);
                        r.ok = 1'b1;
                        r.start_word = top;
                        r.size_words = words;
                    end
                end
            end
            FUNC_RELEASE: begin
                if (c.endpoint < ENDPOINTS) begin
                    if (c.endpoint != 0) free_slot(c.endpoint);
                    r.ok = 1'b1;
                end
            end
            FUNC_RELEASE_ALL: begin
                for (i = 1; i < ENDPOINTS; i++) free_slot(i);
                r.ok = 1'b1;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_in_item rand_cmd();
        t_in_item c;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 62) c.func = FUNC_ALLOC;
        else if (pick < 90) c.func = FUNC_RELEASE;
        else if (pick < 96) c.func = FUNC_RELEASE_ALL;
        else c.func = FUNC_UNUSED;
        c.endpoint = ($urandom_range(99) < 85) ? 3'($urandom_range(1, 5))
                                               : 3'($urandom_range(0, 7));
        pick = $urandom_range(99);
        if (pick < 40) c.request_bytes = 10'($urandom_range(0, 64));
        else if (pick < 50) c.request_bytes = 10'd1023;
        else if (pick < 55) c.request_bytes = 10'd0;
        else c.request_bytes = 10'($urandom_range(0, 1023));
        c.double_size = 1'($urandom_range(1));
        return c;
    endfunction

    task automatic push_cmd(input logic [1:0] func, input logic [2:0] ep,
                            input logic [9:0] bytes, input logic dbl);
        t_in_item c;
        c.func = func;
        c.endpoint = ep;
        c.request_bytes = bytes;
        c.double_size = dbl;
        cmd_queue.push_back(c);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_EP0_START: ep0_start = val;
            CFG_EP0_DEPTH: ep0_depth = val;
            CFG_TOTAL: fifo_total = val;
            default: ;
        endcase
    endtask

    // sender holds off until every result is back, then the block is idle
    task automatic settle();
        do begin
            while (cmd_queue.size() != 0 || i_valid || region_answers.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end while (cmd_queue.size() != 0 || i_valid || region_answers.size() != 0);
    endtask

    task automatic run_phase(input logic [15:0] start, input logic [15:0] depth,
                             input logic [15:0] total, input int count,
                             input int unsigned pct);
        int n;
        cfg_write(CFG_EP0_START, start);
        cfg_write(CFG_EP0_DEPTH, depth);
        cfg_write(CFG_TOTAL, total);
        gap_pct = pct;
        for (n = 0; n < count; n++) cmd_queue.push_back(rand_cmd());
        settle();
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) region_answers.push_back(apply_fifo_cmd(i_in));
            if (!i_valid || !o_stall) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    i_in <= cmd_queue.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (region_answers.size() == 0) begin
                    $display("%0t: unexpected result ok=%0b start=%h size=%0d",
                             $time, o_out.ok, o_out.start_word, o_out.size_words);
                    fail_count++;
                end else begin
                    want = region_answers.pop_front();
                    if (o_out.ok !== want.ok) begin
                        $display("%0t: ok expected %0b actual %0b",
                                 $time, want.ok, o_out.ok);
                        fail_count++;
                    end
                    if (o_out.start_word !== want.start_word) begin
                        $display("%0t: start_word expected %h actual %h",
                                 $time, want.start_word, o_out.start_word);
                        fail_count++;
                    end
                    if (o_out.size_words !== want.size_words) begin
                        $display("%0t: size_words expected %0d actual %0d",
                                 $time, want.size_words, o_out.size_words);
                        fail_count++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < gap_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int n;
        for (n = 1; n < ENDPOINTS; n++) free_slot(n);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset configuration
        push_cmd(FUNC_ALLOC, 3'd0, 10'd100, 1'b0);
        push_cmd(FUNC_ALLOC, 3'd1, 10'd0, 1'b0);
        push_cmd(FUNC_ALLOC, 3'd2, 10'd1023, 1'b1);
        push_cmd(FUNC_ALLOC, 3'd3, 10'd1023, 1'b0);
        push_cmd(FUNC_ALLOC, 3'd3, 10'd5, 1'b0);
        push_cmd(FUNC_ALLOC, 3'd4, 10'd65, 1'b0);
        push_cmd(FUNC_ALLOC, 3'd5, 10'd64, 1'b1);
        push_cmd(FUNC_ALLOC, 3'd1, 10'd200, 1'b0);
        push_cmd(FUNC_ALLOC, 3'd5, 10'd512, 1'b0);
        push_cmd(FUNC_RELEASE, 3'd0, 10'd0, 1'b0);
        push_cmd(FUNC_RELEASE, 3'd1, 10'd0, 1'b0);
        push_cmd(FUNC_RELEASE, 3'd6, 10'd0, 1'b0);
        push_cmd(FUNC_RELEASE, 3'd7, 10'd1023, 1'b1);
        push_cmd(FUNC_ALLOC, 3'd6, 10'd10, 1'b0);
        push_cmd(FUNC_ALLOC, 3'd7, 10'd1023, 1'b1);
        push_cmd(FUNC_UNUSED, 3'd3, 10'd1023, 1'b1);
        push_cmd(FUNC_RELEASE_ALL, 3'd7, 10'd1023, 1'b1);
        push_cmd(FUNC_ALLOC, 3'd2, 10'd1, 1'b1);
        push_cmd(FUNC_ALLOC, 3'd5, 10'd1020, 1'b0);
        push_cmd(FUNC_ALLOC, 3'd4, 10'd0, 1'b1);
        push_cmd(FUNC_RELEASE, 3'd4, 10'd513, 1'b1);
        for (n = 0; n < 80; n++) cmd_queue.push_back(rand_cmd());
        settle();

        run_phase(16'd0, 16'd0, 16'd16, 60, 11);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 50, 11);
        // ep0 region wraps past the top of the word space
        run_phase(16'hFFF0, 16'h0020, 16'h0400, 120, 0);
        // allocations cross the free limit and drop out of the scan
        run_phase(16'h01F0, 16'h0008, 16'hFFFF, 120, 11);
        cfg_write(CFG_UNUSED, 16'hBEEF);
        run_phase(16'd0, 16'h0100, 16'h0300, 150, 11);
        run_phase(16'($urandom_range(0, 16'h0300)), 16'($urandom_range(0, 16'h0100)),
                  16'($urandom_range(16, 16'h0800)), 100, 11);
        run_phase(RST_EP0_START, RST_EP0_DEPTH, RST_TOTAL, 150, 11);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
